[rtl/core/voxel_boundary_face_emitter_core_defines.svh]
// ----------------------------------------------------------------------------
// voxel boundary face emitter assertion macros
// assertion helpers for the checker file of this block
// ----------------------------------------------------------------------------
`ifndef VOXEL_BOUNDARY_FACE_EMITTER_CORE_DEFINES_SVH
`define VOXEL_BOUNDARY_FACE_EMITTER_CORE_DEFINES_SVH

// assertion on an explicit clock and active-low reset
`define VBFE_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// assertion on the block clock and reset
`define VBFE_ASSERT(lbl, prop, msg) \
  `VBFE_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

[rtl/core/vbfe_pkg.sv]
// ----------------------------------------------------------------------------
// vbfe_pkg
// types, codes and helper functions of the voxel boundary face emitter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vbfe_pkg;

  localparam int unsigned COORD_W    = 20;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned POS_W      = 8;
  localparam int unsigned POS_RANGE  = 256;
  localparam int unsigned DIM_W      = 9;
  localparam int unsigned VERTEX_W   = 3 * COORD_W;
  localparam int unsigned NUM_SLOTS  = 6;
  localparam int unsigned SLOT_W     = 3;
  localparam int unsigned PADDR_W    = 4;
  localparam int unsigned PDATA_W    = 32;

  localparam logic [PIX_W-1:0] SOLID_PIXEL = 8'hff;

  localparam logic [DIM_W-1:0]   RST_IMAGE_WIDTH  = 9'd256;
  localparam logic [DIM_W-1:0]   RST_IMAGE_HEIGHT = 9'd256;
  localparam logic [COORD_W-1:0] RST_FIRST_LAYER  = 20'd0;
  localparam logic [COORD_W-1:0] RST_LAST_LAYER   = 20'd1;

  // corner offsets from a face origin, bit order {dz, dy, dx}
  localparam logic [2:0] OFF_0  = 3'b000;
  localparam logic [2:0] OFF_X  = 3'b001;
  localparam logic [2:0] OFF_Y  = 3'b010;
  localparam logic [2:0] OFF_XY = 3'b011;
  localparam logic [2:0] OFF_Z  = 3'b100;
  localparam logic [2:0] OFF_XZ = 3'b101;
  localparam logic [2:0] OFF_YZ = 3'b110;

  typedef logic [COORD_W-1:0]  coord_t;
  typedef logic [VERTEX_W-1:0] vertex_t;

  typedef enum logic [2:0] {
    FACE_FRONT = 3'd0,
    FACE_BACK  = 3'd1,
    FACE_LEFT  = 3'd2,
    FACE_RIGHT = 3'd3,
    FACE_UP    = 3'd4,
    FACE_DOWN  = 3'd5
  } facing_e;

  // face slots in emission order
  typedef enum logic [SLOT_W-1:0] {
    SLOT_LOW_X  = 3'd0,
    SLOT_HIGH_X = 3'd1,
    SLOT_LOW_Y  = 3'd2,
    SLOT_HIGH_Y = 3'd3,
    SLOT_LOW_Z  = 3'd4,
    SLOT_TOP    = 3'd5
  } slot_e;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_FIRST_LAYER  = 2'd2,
    REG_LAST_LAYER   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    coord_t           layer;
  } in_item_t;

  typedef struct packed {
    logic [2:0] facing;
    vertex_t    vertex_a;
    vertex_t    vertex_b;
    vertex_t    vertex_c;
    logic       last_triangle;
  } out_item_t;

  typedef struct packed {
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    coord_t           first_layer;
    coord_t           last_layer;
  } cfg_t;

  // stored occupancy of the three neighbors
  typedef struct packed {
    logic left;
    logic above;
    logic below;
  } nbr_t;

  typedef struct packed {
    logic                 pending_any;
    logic [NUM_SLOTS-1:0] slot_oh;
    logic                 last;
  } tri_ctl_t;

  typedef struct packed {
    logic [2:0] a;
    logic [2:0] b;
    logic [2:0] c;
  } corners_t;

  // corners of one of the two triangles of a unit face
  function automatic corners_t tri_corners(facing_e f, logic half);
    corners_t c;
    case (f)
      FACE_LEFT:  c = half ? {OFF_Z, OFF_YZ, OFF_Y} : {OFF_0, OFF_Z, OFF_Y};
      FACE_RIGHT: c = half ? {OFF_Z, OFF_Y, OFF_YZ} : {OFF_0, OFF_Y, OFF_Z};
      FACE_FRONT: c = half ? {OFF_Z, OFF_X, OFF_XZ} : {OFF_Z, OFF_0, OFF_X};
      FACE_BACK:  c = half ? {OFF_Z, OFF_XZ, OFF_X} : {OFF_0, OFF_Z, OFF_X};
      FACE_DOWN:  c = half ? {OFF_Y, OFF_XY, OFF_X} : {OFF_0, OFF_Y, OFF_X};
      FACE_UP:    c = half ? {OFF_Y, OFF_X, OFF_XY} : {OFF_Y, OFF_0, OFF_X};
      default:    c = {OFF_0, OFF_0, OFF_0};
    endcase
    return c;
  endfunction

  // packed vertex, each coordinate wraps at 20 bits
  function automatic vertex_t vertex_at(coord_t x, coord_t y, coord_t z, logic [2:0] off);
    coord_t vx;
    coord_t vy;
    coord_t vz;
    vx = x + {{(COORD_W-1){1'b0}}, off[0]};
    vy = y + {{(COORD_W-1){1'b0}}, off[1]};
    vz = z + {{(COORD_W-1){1'b0}}, off[2]};
    return {vz, vy, vx};
  endfunction

endpackage

[rtl/core/vbfe_apb_regs.sv]
// ----------------------------------------------------------------------------
// vbfe_apb_regs
// configuration registers behind an apb-style write/read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vbfe_apb_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vbfe_pkg::PADDR_W-1:0]  paddr,
  input  logic [vbfe_pkg::PDATA_W-1:0]  pwdata,
  output logic [vbfe_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output vbfe_pkg::cfg_t                cfg_o
);

  vbfe_pkg::cfg_t     cfg_d, cfg_q;
  vbfe_pkg::reg_idx_e reg_idx;
  logic               wr_en;

  assign pready  = 1'b1;
  assign reg_idx = vbfe_pkg::reg_idx_e'(paddr[vbfe_pkg::PADDR_W-1:2]);
  assign wr_en   = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        vbfe_pkg::REG_IMAGE_WIDTH:  cfg_d.image_width  = pwdata[vbfe_pkg::DIM_W-1:0];
        vbfe_pkg::REG_IMAGE_HEIGHT: cfg_d.image_height = pwdata[vbfe_pkg::DIM_W-1:0];
        vbfe_pkg::REG_FIRST_LAYER:  cfg_d.first_layer  = pwdata[vbfe_pkg::COORD_W-1:0];
        vbfe_pkg::REG_LAST_LAYER:   cfg_d.last_layer   = pwdata[vbfe_pkg::COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      vbfe_pkg::REG_IMAGE_WIDTH:  prdata = vbfe_pkg::PDATA_W'(cfg_q.image_width);
      vbfe_pkg::REG_IMAGE_HEIGHT: prdata = vbfe_pkg::PDATA_W'(cfg_q.image_height);
      vbfe_pkg::REG_FIRST_LAYER:  prdata = vbfe_pkg::PDATA_W'(cfg_q.first_layer);
      vbfe_pkg::REG_LAST_LAYER:   prdata = vbfe_pkg::PDATA_W'(cfg_q.last_layer);
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= vbfe_pkg::RST_IMAGE_WIDTH;
      cfg_q.image_height <= vbfe_pkg::RST_IMAGE_HEIGHT;
      cfg_q.first_layer  <= vbfe_pkg::RST_FIRST_LAYER;
      cfg_q.last_layer   <= vbfe_pkg::RST_LAST_LAYER;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/core/vbfe_tri_gen.sv]
// ----------------------------------------------------------------------------
// vbfe_tri_gen
// face detection for one voxel and selection of the next triangle to emit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vbfe_tri_gen (
  input  vbfe_pkg::in_item_t                  item_i,
  input  vbfe_pkg::nbr_t                      nbr_i,
  input  vbfe_pkg::cfg_t                      cfg_i,
  input  logic [vbfe_pkg::NUM_SLOTS-1:0]      consumed_i,
  input  logic                                half_i,
  output vbfe_pkg::out_item_t                 tri_o,
  output vbfe_pkg::tri_ctl_t                  ctl_o
);

  logic                            occ;
  logic                            at_first;
  logic                            last_tri;
  logic [vbfe_pkg::NUM_SLOTS-1:0]  face_mask;
  logic [vbfe_pkg::NUM_SLOTS-1:0]  pending;
  logic [vbfe_pkg::NUM_SLOTS-1:0]  slot_oh;
  vbfe_pkg::slot_e                 slot_idx;
  vbfe_pkg::facing_e               f_x_low, f_y_low, f_z_low, sel_facing;
  vbfe_pkg::coord_t                x0, y0, z0, ox, oy, oz;
  vbfe_pkg::corners_t              corners;

  always_comb begin
    occ      = |item_i.pixel;
    at_first = item_i.layer == cfg_i.first_layer;
    x0       = {{(vbfe_pkg::COORD_W-vbfe_pkg::POS_W){1'b0}}, item_i.col};
    y0       = {{(vbfe_pkg::COORD_W-vbfe_pkg::POS_W){1'b0}}, item_i.row};
    z0       = item_i.layer;

    // low side faces: outer at the border, else change of occupancy
    face_mask[vbfe_pkg::SLOT_LOW_X] = (item_i.col == '0) ? occ : (occ ^ nbr_i.left);
    face_mask[vbfe_pkg::SLOT_LOW_Y] = (item_i.row == '0) ? occ : (occ ^ nbr_i.above);
    // only fully solid pixels close the bottom layer
    face_mask[vbfe_pkg::SLOT_LOW_Z] = at_first ? (item_i.pixel == vbfe_pkg::SOLID_PIXEL)
                                               : (occ ^ nbr_i.below);
    face_mask[vbfe_pkg::SLOT_HIGH_X] = occ &&
        (({1'b0, item_i.col} + 9'd1) == cfg_i.image_width);
    face_mask[vbfe_pkg::SLOT_HIGH_Y] = occ &&
        (({1'b0, item_i.row} + 9'd1) == cfg_i.image_height);
    face_mask[vbfe_pkg::SLOT_TOP] = occ && (item_i.layer == cfg_i.last_layer);

    f_x_low = (item_i.col == '0 || !nbr_i.left) ? vbfe_pkg::FACE_LEFT : vbfe_pkg::FACE_RIGHT;
    f_y_low = (item_i.row == '0 || !nbr_i.above) ? vbfe_pkg::FACE_FRONT : vbfe_pkg::FACE_BACK;
    f_z_low = (at_first || !nbr_i.below) ? vbfe_pkg::FACE_DOWN : vbfe_pkg::FACE_UP;

    pending  = face_mask & ~consumed_i;

    // lowest pending slot goes first
    slot_idx = vbfe_pkg::SLOT_LOW_X;
    for (int i = vbfe_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (pending[i]) begin
        slot_idx = vbfe_pkg::slot_e'(i);
      end
    end
    slot_oh = '0;
    if (|pending) begin
      slot_oh[slot_idx] = 1'b1;
    end

    ox         = x0;
    oy         = y0;
    oz         = z0;
    sel_facing = f_x_low;
    case (slot_idx)
      vbfe_pkg::SLOT_LOW_X:  sel_facing = f_x_low;
      vbfe_pkg::SLOT_HIGH_X: begin
        sel_facing = vbfe_pkg::FACE_RIGHT;
        ox         = x0 + 20'd1;
      end
      vbfe_pkg::SLOT_LOW_Y:  sel_facing = f_y_low;
      vbfe_pkg::SLOT_HIGH_Y: begin
        sel_facing = vbfe_pkg::FACE_BACK;
        oy         = y0 + 20'd1;
      end
      vbfe_pkg::SLOT_LOW_Z:  sel_facing = f_z_low;
      vbfe_pkg::SLOT_TOP: begin
        sel_facing = vbfe_pkg::FACE_UP;
        oz         = z0 + 20'd1;
      end
      default: ;
    endcase

    corners  = vbfe_pkg::tri_corners(sel_facing, half_i);
    last_tri = half_i && ((pending & ~slot_oh) == '0);
  end

  always_comb begin
    tri_o.facing        = sel_facing;
    tri_o.vertex_a      = vbfe_pkg::vertex_at(ox, oy, oz, corners.a);
    tri_o.vertex_b      = vbfe_pkg::vertex_at(ox, oy, oz, corners.b);
    tri_o.vertex_c      = vbfe_pkg::vertex_at(ox, oy, oz, corners.c);
    tri_o.last_triangle = last_tri;
    ctl_o.pending_any   = |pending;
    ctl_o.slot_oh       = slot_oh;
    ctl_o.last          = last_tri;
  end

endmodule

[rtl/core/voxel_boundary_face_emitter_core.sv]
// ----------------------------------------------------------------------------
// voxel_boundary_face_emitter_core
// datapath: accepted voxel in the item register, triangles in the output register
// throughput: one voxel per cycle when it has no faces, else the voxel is held
//   till its triangles (2 to 12) leave; the single triangle output register sets the pace
// reset: control state and config registers reset, occupancy stores do not
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module voxel_boundary_face_emitter_core #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // voxel input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  vbfe_pkg::in_item_t            in_data_i,
  // triangle output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output vbfe_pkg::out_item_t           out_data_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vbfe_pkg::PADDR_W-1:0]  paddr,
  input  logic [vbfe_pkg::PDATA_W-1:0]  pwdata,
  output logic [vbfe_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  // only 256 column and row positions can arrive, so the stores never
  // need more entries than that along either axis
  localparam int unsigned COL_SPAN = (MAX_WIDTH  < vbfe_pkg::POS_RANGE) ? MAX_WIDTH
                                                                      : vbfe_pkg::POS_RANGE;
  localparam int unsigned ROW_SPAN = (MAX_HEIGHT < vbfe_pkg::POS_RANGE) ? MAX_HEIGHT
                                                                      : vbfe_pkg::POS_RANGE;
  localparam int unsigned CW = (COL_SPAN > 1) ? $clog2(COL_SPAN) : 1;
  localparam int unsigned RW = (ROW_SPAN > 1) ? $clog2(ROW_SPAN) : 1;
  localparam int unsigned LAYER_AW    = CW + RW;
  localparam int unsigned LAYER_DEPTH = 2 ** LAYER_AW;
  localparam int unsigned ROW_DEPTH   = 2 ** CW;

  vbfe_pkg::cfg_t cfg;

  vbfe_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // --------------------------------------------------------------------------
  // store addressing: col and row wrap at MAX_WIDTH and MAX_HEIGHT
  // --------------------------------------------------------------------------
  logic [CW-1:0] col_map [vbfe_pkg::POS_RANGE];
  logic [RW-1:0] row_map [vbfe_pkg::POS_RANGE];

  for (genvar g = 0; g < vbfe_pkg::POS_RANGE; g++) begin : g_addr_map
    assign col_map[g] = CW'(g % MAX_WIDTH);
    assign row_map[g] = RW'(g % MAX_HEIGHT);
  end

  logic [CW-1:0]       cidx;
  logic [LAYER_AW-1:0] layer_addr;
  logic                occ_in;
  logic                in_fire;

  assign cidx       = col_map[in_data_i.col];
  // {row, col} after wrapping is a unique slot per position, the only property needed
  assign layer_addr = {row_map[in_data_i.row], cidx};
  assign occ_in     = |in_data_i.pixel;
  assign in_fire    = in_valid_i & in_ready_o;

  // --------------------------------------------------------------------------
  // occupancy stores: read-first, read and written on the accepting edge,
  // so each voxel sees what its predecessor left without forwarding
  // --------------------------------------------------------------------------
  logic layer_mem [LAYER_DEPTH];
  logic row_mem   [ROW_DEPTH];
  logic below_rd_q;
  logic above_rd_q;
  logic left_q;
  logic s1_left_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      below_rd_q             <= layer_mem[layer_addr];
      layer_mem[layer_addr]  <= occ_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      above_rd_q     <= row_mem[cidx];
      row_mem[cidx]  <= occ_in;
    end
  end

  // left neighbor is simply the previous voxel
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_left_q <= left_q;
      left_q    <= occ_in;
    end
  end

  // --------------------------------------------------------------------------
  // item register and triangle sequencing
  // --------------------------------------------------------------------------
  vbfe_pkg::in_item_t             s1_item_q;
  logic                           s1_valid_d, s1_valid_q;
  logic [vbfe_pkg::NUM_SLOTS-1:0] consumed_d, consumed_q;
  logic                           half_d, half_q;
  vbfe_pkg::nbr_t                 nbr;
  vbfe_pkg::out_item_t            tri_next;
  vbfe_pkg::tri_ctl_t             tri_ctl;

  assign nbr.left  = s1_left_q;
  assign nbr.above = above_rd_q;
  assign nbr.below = below_rd_q;

  vbfe_tri_gen u_tri_gen (
    .item_i     (s1_item_q),
    .nbr_i      (nbr),
    .cfg_i      (cfg),
    .consumed_i (consumed_q),
    .half_i     (half_q),
    .tri_o      (tri_next),
    .ctl_o      (tri_ctl)
  );

  logic emit;
  logic s1_done;
  logic out_valid_d, out_valid_q;
  vbfe_pkg::out_item_t out_q;

  // a triangle moves into the output register when that register is free
  // or its current transaction completes this cycle
  assign emit    = s1_valid_q & tri_ctl.pending_any & (~out_valid_q | out_ready_i);
  // voxel retires when it has no faces left or its final triangle leaves now
  assign s1_done = s1_valid_q & (~tri_ctl.pending_any | (emit & tri_ctl.last));
  assign in_ready_o = ~s1_valid_q | s1_done;

  always_comb begin
    s1_valid_d = s1_valid_q;
    consumed_d = consumed_q;
    half_d     = half_q;
    if (s1_done) begin
      s1_valid_d = 1'b0;
    end
    if (emit) begin
      if (half_q) begin
        consumed_d = consumed_q | tri_ctl.slot_oh;
        half_d     = 1'b0;
      end else begin
        half_d = 1'b1;
      end
    end
    if (in_fire) begin
      s1_valid_d = 1'b1;
      consumed_d = '0;
      half_d     = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      consumed_q  <= '0;
      half_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      consumed_q  <= consumed_d;
      half_q      <= half_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= in_data_i;
    end
    if (emit) begin
      out_q <= tri_next;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[rtl/core/vbfe_core_checker.sv]
// ----------------------------------------------------------------------------
// vbfe_core_checker
// port-level checks on the triangle output of the face emitter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "voxel_boundary_face_emitter_core_defines.svh"

module vbfe_core_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input vbfe_pkg::out_item_t out_data_o
);

  // a stalled triangle stays offered
  `VBFE_ASSERT(a_out_valid_hold, out_valid_o && !out_ready_i |=> out_valid_o, "out valid dropped")

  // a stalled triangle keeps its payload
  `VBFE_ASSERT(a_out_data_hold, out_valid_o && !out_ready_i |=> $stable(out_data_o), "out data moved")

  // a burst continues without a gap until its final triangle
  `VBFE_ASSERT(a_burst_no_gap, out_valid_o && out_ready_i && !out_data_o.last_triangle |=> out_valid_o, "gap in triangle burst")

  // x faces lie in one plane of constant x
  `VBFE_ASSERT(a_x_face_plane, out_valid_o && (out_data_o.facing == vbfe_pkg::FACE_LEFT || out_data_o.facing == vbfe_pkg::FACE_RIGHT) |-> (out_data_o.vertex_a[19:0] == out_data_o.vertex_b[19:0]) && (out_data_o.vertex_b[19:0] == out_data_o.vertex_c[19:0]), "x face not planar")

endmodule

bind voxel_boundary_face_emitter_core vbfe_core_checker u_vbfe_core_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

[dv/voxel_boundary_face_emitter_core_test.sv]
// ----------------------------------------------------------------------------
// voxel_boundary_face_emitter_core_test
// self-checking testbench for the voxel boundary face emitter: streams voxel
// volumes and random voxels through the core under random input gaps and
// output stalls, predicts every triangle in order and compares field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module voxel_boundary_face_emitter_core_test;

  localparam int unsigned ITEM_TARGET    = 330;
  localparam int unsigned TAIL_ITEMS     = 40;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned MAX_LAYER      = 1048574;

  // cube corner offsets from a face origin, bit order {dz, dy, dx}
  localparam logic [2:0] CRN_0  = 3'b000;
  localparam logic [2:0] CRN_X  = 3'b001;
  localparam logic [2:0] CRN_Y  = 3'b010;
  localparam logic [2:0] CRN_XY = 3'b011;
  localparam logic [2:0] CRN_Z  = 3'b100;
  localparam logic [2:0] CRN_XZ = 3'b101;
  localparam logic [2:0] CRN_YZ = 3'b110;

  // ------------------------------------------------------------------------
  // dut signals, every input known from time zero
  // ------------------------------------------------------------------------
  logic                          clk_i     = 1'b0;
  logic                          rst_ni    = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  vbfe_pkg::in_item_t            in_data   = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  vbfe_pkg::out_item_t           out_data;
  logic                          psel      = 1'b0;
  logic                          penable   = 1'b0;
  logic                          pwrite    = 1'b0;
  logic [vbfe_pkg::PADDR_W-1:0]  paddr     = '0;
  logic [vbfe_pkg::PDATA_W-1:0]  pwdata    = '0;
  logic [vbfe_pkg::PDATA_W-1:0]  prdata;
  logic                          pready;

  voxel_boundary_face_emitter_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // ------------------------------------------------------------------------
  // testbench state
  // ------------------------------------------------------------------------
  vbfe_pkg::in_item_t  voxel_queue [$];        // voxels waiting to be driven
  vbfe_pkg::out_item_t pending_triangles [$];  // predicted triangles not yet seen
  vbfe_pkg::out_item_t voxel_tris [$];         // triangles of the voxel being predicted

  // register copy, in force whenever voxels are in flight
  vbfe_pkg::cfg_t cur_cfg = {vbfe_pkg::RST_IMAGE_WIDTH, vbfe_pkg::RST_IMAGE_HEIGHT,
                             vbfe_pkg::RST_FIRST_LAYER, vbfe_pkg::RST_LAST_LAYER};

  // occupancy the predictor keeps of the neighbors
  bit          occ_layer [0:65535];
  bit          occ_row [0:255];
  bit          occ_left;

  // store entries already written by queued voxels; stimulus never reads
  // an entry that is still undefined
  bit          gen_seen_layer [0:65535];
  bit          gen_seen_row [0:255];
  bit          gen_seen_left;

  int unsigned voxel_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned send_gap       = 0;
  int unsigned recv_stall     = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned mismatches     = 0;

  // ------------------------------------------------------------------------
  // triangle predictor
  // ------------------------------------------------------------------------

  // one corner of a face, each coordinate wrapping at 20 bits
  function automatic vbfe_pkg::vertex_t corner_vertex(int unsigned fx, int unsigned fy,
                                                      int unsigned fz, logic [2:0] d);
    vbfe_pkg::coord_t vx;
    vbfe_pkg::coord_t vy;
    vbfe_pkg::coord_t vz;
    vx = vbfe_pkg::coord_t'(fx + d[0]);
    vy = vbfe_pkg::coord_t'(fy + d[1]);
    vz = vbfe_pkg::coord_t'(fz + d[2]);
    return {vz, vy, vx};
  endfunction

  // both triangles of a unit face; winding depends on the normal
  function automatic void emit_face(vbfe_pkg::facing_e f, int unsigned fx,
                                    int unsigned fy, int unsigned fz);
    logic [17:0]         crn;
    vbfe_pkg::out_item_t tri_item;
    case (f)
      vbfe_pkg::FACE_LEFT:  crn = {CRN_0, CRN_Z, CRN_Y, CRN_Z, CRN_YZ, CRN_Y};
      vbfe_pkg::FACE_RIGHT: crn = {CRN_0, CRN_Y, CRN_Z, CRN_Z, CRN_Y, CRN_YZ};
      vbfe_pkg::FACE_FRONT: crn = {CRN_Z, CRN_0, CRN_X, CRN_Z, CRN_X, CRN_XZ};
      vbfe_pkg::FACE_BACK:  crn = {CRN_0, CRN_Z, CRN_X, CRN_Z, CRN_XZ, CRN_X};
      vbfe_pkg::FACE_DOWN:  crn = {CRN_0, CRN_Y, CRN_X, CRN_Y, CRN_XY, CRN_X};
      vbfe_pkg::FACE_UP:    crn = {CRN_Y, CRN_0, CRN_X, CRN_Y, CRN_X, CRN_XY};
      default:              crn = '0;
    endcase
    for (int h = 0; h < 2; h++) begin
      tri_item.facing        = f;
      tri_item.vertex_a      = corner_vertex(fx, fy, fz, crn[17-9*h -: 3]);
      tri_item.vertex_b      = corner_vertex(fx, fy, fz, crn[14-9*h -: 3]);
      tri_item.vertex_c      = corner_vertex(fx, fy, fz, crn[11-9*h -: 3]);
      tri_item.last_triangle = 1'b0;
      voxel_tris.push_back(tri_item);
    end
  endfunction

  // all triangles of one accepted voxel, in emission order
  function automatic void predict_faces(vbfe_pkg::in_item_t v);
    bit                  occ;
    bit                  nb_left;
    bit                  nb_above;
    bit                  nb_below;
    int unsigned         x;
    int unsigned         y;
    int unsigned         z;
    int unsigned         n;
    vbfe_pkg::out_item_t tri_item;
    occ      = (v.pixel != '0);
    x        = v.col;
    y        = v.row;
    z        = v.layer;
    nb_left  = occ_left;
    nb_above = occ_row[v.col];
    nb_below = occ_layer[{v.row, v.col}];
    voxel_tris.delete();

    // low-x plane: image border, else inner left or right
    if (x == 0) begin
      if (occ) emit_face(vbfe_pkg::FACE_LEFT, 0, y, z);
    end else if (!nb_left && occ) begin
      emit_face(vbfe_pkg::FACE_LEFT, x, y, z);
    end else if (nb_left && !occ) begin
      emit_face(vbfe_pkg::FACE_RIGHT, x, y, z);
    end
    if (occ && x + 1 == cur_cfg.image_width) emit_face(vbfe_pkg::FACE_RIGHT, x + 1, y, z);

    // low-y plane against the row before
    if (y == 0) begin
      if (occ) emit_face(vbfe_pkg::FACE_FRONT, x, 0, z);
    end else if (!nb_above && occ) begin
      emit_face(vbfe_pkg::FACE_FRONT, x, y, z);
    end else if (nb_above && !occ) begin
      emit_face(vbfe_pkg::FACE_BACK, x, y, z);
    end
    if (occ && y + 1 == cur_cfg.image_height) emit_face(vbfe_pkg::FACE_BACK, x, y + 1, z);

    // low-z plane: only fully solid voxels close the bottom layer
    if (v.layer == cur_cfg.first_layer) begin
      if (v.pixel == vbfe_pkg::SOLID_PIXEL) emit_face(vbfe_pkg::FACE_DOWN, x, y, z);
    end else if (!nb_below && occ) begin
      emit_face(vbfe_pkg::FACE_DOWN, x, y, z);
    end else if (nb_below && !occ) begin
      emit_face(vbfe_pkg::FACE_UP, x, y, z);
    end
    if (occ && v.layer == cur_cfg.last_layer) emit_face(vbfe_pkg::FACE_UP, x, y, z + 1);

    n = voxel_tris.size();
    if (n > 0) begin
      tri_item = voxel_tris[n-1];
      tri_item.last_triangle = 1'b1;
      voxel_tris[n-1] = tri_item;
    end
    foreach (voxel_tris[i]) pending_triangles.push_back(voxel_tris[i]);

    occ_layer[{v.row, v.col}] = occ;
    occ_row[v.col]            = occ;
    occ_left                  = occ;
  endfunction

  // ------------------------------------------------------------------------
  // checking
  // ------------------------------------------------------------------------
  function automatic void check_field(string name, logic [63:0] exp_val,
                                      logic [63:0] got_val);
    if (exp_val !== got_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
      mismatches++;
    end
  endfunction

  function automatic void check_triangle(vbfe_pkg::out_item_t got);
    vbfe_pkg::out_item_t want;
    if (pending_triangles.size() == 0) begin
      $error("triangle with no voxel behind it: facing %0d, vertex_a 0x%0h",
             got.facing, got.vertex_a);
      mismatches++;
    end else begin
      want = pending_triangles.pop_front();
      check_field("facing", want.facing, got.facing);
      check_field("vertex_a", want.vertex_a, got.vertex_a);
      check_field("vertex_b", want.vertex_b, got.vertex_b);
      check_field("vertex_c", want.vertex_c, got.vertex_c);
      check_field("last_triangle", want.last_triangle, got.last_triangle);
    end
  endfunction

  // ------------------------------------------------------------------------
  // voxel driver: holds valid and payload until the transaction completes,
  // then either starts an idle burst or presents the next queued voxel
  // ------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      send_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (voxel_queue.size() > 0) begin
        in_valid <= 1'b1;
        in_data  <= voxel_queue.pop_front();
        // idle burst after this voxel is taken
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
          send_gap <= $urandom_range(1, 12);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // triangle sink: ready with random stall bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready  <= 1'b0;
      recv_stall <= 0;
    end else if (recv_stall > 0) begin
      recv_stall <= recv_stall - 1;
      out_ready  <= 1'b0;
    end else if (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct) begin
      recv_stall <= $urandom_range(0, 11);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor: predict on each voxel transaction, check each triangle
  // transaction, count cycles in which nothing moves
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) predict_faces(in_data);
      if (out_valid && out_ready) check_triangle(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles = quiet_cycles + 1;
    end
  end

  // watchdog
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(negedge clk_i);
    $display("voxel_boundary_face_emitter_core_test: FAIL");
    $finish;
  end

  // ------------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------------

  // queue one voxel; coordinates that would read a never-written store
  // entry are pulled back to the border or the first layer
  function automatic void queue_voxel(int unsigned pixel, int unsigned col,
                                      int unsigned row, int unsigned layer);
    vbfe_pkg::in_item_t v;
    v.pixel = pixel[vbfe_pkg::PIX_W-1:0];
    v.col   = col[vbfe_pkg::POS_W-1:0];
    v.row   = row[vbfe_pkg::POS_W-1:0];
    v.layer = layer[vbfe_pkg::COORD_W-1:0];
    if (v.col != '0 && !gen_seen_left) v.col = '0;
    if (v.row != '0 && !gen_seen_row[v.col]) v.row = '0;
    if (v.layer != cur_cfg.first_layer && !gen_seen_layer[{v.row, v.col}])
      v.layer = cur_cfg.first_layer;
    gen_seen_left                 = 1'b1;
    gen_seen_row[v.col]           = 1'b1;
    gen_seen_layer[{v.row, v.col}] = 1'b1;
    voxel_queue.push_back(v);
    voxel_count++;
  endfunction

  // mostly empty or solid voxels so that surfaces form, some partial
  function automatic int unsigned random_pixel();
    case ($urandom_range(0, 4))
      0, 1:    return 0;
      2, 3:    return vbfe_pkg::SOLID_PIXEL;
      default: return $urandom_range(1, 254);
    endcase
  endfunction

  // sender holds off until every predicted triangle is out and the core
  // has had time to finish a voxel without faces
  task automatic wait_idle();
    do @(negedge clk_i);
    while (voxel_queue.size() != 0 || in_valid || pending_triangles.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // apb write: setup cycle, then access cycle
  task automatic write_reg(vbfe_pkg::reg_idx_e idx, logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      vbfe_pkg::REG_IMAGE_WIDTH:  cur_cfg.image_width  = value[vbfe_pkg::DIM_W-1:0];
      vbfe_pkg::REG_IMAGE_HEIGHT: cur_cfg.image_height = value[vbfe_pkg::DIM_W-1:0];
      vbfe_pkg::REG_FIRST_LAYER:  cur_cfg.first_layer  = value[vbfe_pkg::COORD_W-1:0];
      vbfe_pkg::REG_LAST_LAYER:   cur_cfg.last_layer   = value[vbfe_pkg::COORD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int unsigned w, int unsigned h, int unsigned first,
                            int unsigned last);
    wait_idle();
    write_reg(vbfe_pkg::REG_IMAGE_WIDTH, w);
    write_reg(vbfe_pkg::REG_IMAGE_HEIGHT, h);
    write_reg(vbfe_pkg::REG_FIRST_LAYER, first);
    write_reg(vbfe_pkg::REG_LAST_LAYER, last);
    @(negedge clk_i);
  endtask

  // one well-formed raster volume with random content, then a few stray
  // voxels around it
  task automatic run_random_phase();
    int unsigned w;
    int unsigned h;
    int unsigned d;
    int unsigned f;
    int unsigned l;
    int unsigned reg_w;
    int unsigned reg_h;
    int unsigned lay;
    int unsigned noise;
    w = $urandom_range(1, 4);
    h = $urandom_range(1, 4);
    d = $urandom_range(1, 3);
    if ($urandom_range(0, 5) == 0) begin
      w = $urandom_range(5, 12);
      h = $urandom_range(1, 2);
    end
    case ($urandom_range(0, 3))
      0:       f = 0;
      1:       f = MAX_LAYER + 1 - d;   // top face of the volume at the coordinate limit
      default: f = $urandom_range(0, MAX_LAYER + 1 - d);
    endcase
    // sometimes first and last coincide while the volume is deeper
    l = ($urandom_range(0, 3) == 0) ? f : f + d - 1;
    reg_w = w;
    reg_h = h;
    case ($urandom_range(0, 5))
      0:       reg_w = 256;
      1:       reg_w = $urandom_range(1, 256);
      default: ;
    endcase
    case ($urandom_range(0, 5))
      0:       reg_h = 256;
      1:       reg_h = $urandom_range(1, 256);
      default: ;
    endcase
    set_config(reg_w, reg_h, f, l);

    // no idling near the end of the run, and stretches without it earlier
    if (voxel_count + w * h * d + TAIL_ITEMS >= ITEM_TARGET) begin
      send_idle_pct  = 0;
      recv_stall_pct = 0;
    end else begin
      case ($urandom_range(0, 2))
        0:       send_idle_pct = 0;
        1:       send_idle_pct = 10;
        default: send_idle_pct = 35;
      endcase
      case ($urandom_range(0, 3))
        0:       recv_stall_pct = 0;
        1:       recv_stall_pct = 15;
        2:       recv_stall_pct = 40;
        default: recv_stall_pct = 70;
      endcase
    end

    for (int z = 0; z < d; z++)
      for (int r = 0; r < h; r++)
        for (int c = 0; c < w; c++)
          queue_voxel(random_pixel(), c, r, f + z);

    noise = $urandom_range(0, 6);
    for (int k = 0; k < noise; k++) begin
      lay = f + $urandom_range(0, d + 1);
      if (lay > MAX_LAYER) lay = MAX_LAYER;
      if (f > 0 && $urandom_range(0, 4) == 0) lay = f - 1;
      if ($urandom_range(0, 3) == 0) lay = $urandom_range(0, MAX_LAYER);
      queue_voxel(random_pixel(), $urandom_range(0, 255),
                  $urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(0, h),
                  lay);
    end
  endtask

  // ------------------------------------------------------------------------
  // test sequence
  // ------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // full-size image, bottom and top on the same layer
    set_config(256, 256, 0, 0);
    queue_voxel(8'hff, 0, 0, 0);     // outer left, front, bottom and top
    queue_voxel(8'h01, 1, 0, 0);     // partial pixel: no bottom face
    queue_voxel(8'h00, 2, 0, 0);     // inner right face
    queue_voxel(8'hfe, 255, 0, 0);   // last column: outer right face
    queue_voxel(8'h00, 0, 1, 0);     // inner back face
    queue_voxel(8'hff, 255, 255, 0); // last row and column corner
    queue_voxel(8'h00, 1, 1, 0);
    queue_voxel(8'h80, 2, 1, 0);
    queue_voxel(8'h00, 3, 1, 0);
    queue_voxel(8'h00, 4, 1, 0);     // empty between empties: no faces
    queue_voxel(8'h00, 0, 0, 1);     // inner up face above the bottom layer
    queue_voxel(8'hff, 1, 0, 1);
    queue_voxel(8'hff, 2, 0, 1);     // inner down face

    // single-voxel image at the top of the coordinate range: all six faces
    set_config(1, 1, MAX_LAYER, MAX_LAYER);
    queue_voxel(8'hff, 0, 0, MAX_LAYER);
    queue_voxel(8'h40, 0, 0, MAX_LAYER);
    queue_voxel(8'h00, 0, 0, MAX_LAYER);

    // two layers, then voxels outside the image and below the first layer
    set_config(1, 1, MAX_LAYER - 1, MAX_LAYER);
    queue_voxel(8'hff, 0, 0, MAX_LAYER - 1);
    queue_voxel(8'h00, 0, 0, MAX_LAYER);
    queue_voxel(8'h07, 0, 0, MAX_LAYER);
    queue_voxel(8'h55, 3, 0, MAX_LAYER - 1);
    queue_voxel(8'hff, 0, 0, MAX_LAYER - 2);

    while (voxel_count < ITEM_TARGET) run_random_phase();

    wait_idle();
    if (mismatches == 0) begin
      $display("voxel_boundary_face_emitter_core_test: PASS");
    end else begin
      $display("voxel_boundary_face_emitter_core_test: FAIL");
    end
    $finish;
  end

endmodule
